// ===== rtl/cjrq_pkg.sv =====
`default_nettype none

package cjrq_pkg;

    localparam int REV_W   = 48;
    localparam int COORD_W = 16;
    localparam int POS_W   = 3 * COORD_W;
    localparam int BOUND_W = 18;

    localparam logic [REV_W-1:0] REV_MAX = {REV_W{1'b1}};

    // Item selector codes
    typedef enum logic [1:0] {
        MODE_RECORD = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } cjrq_mode_t;

    // Result codes
    typedef enum logic [2:0] {
        ANS_NO_CHANGES          = 3'd0,
        ANS_HISTORY_UNAVAILABLE = 3'd1,
        ANS_INTERSECTS          = 3'd2,
        ANS_DISJOINT            = 3'd3,
        ANS_DONE                = 3'd4
    } cjrq_answer_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RECORD,
        ST_CHECK,
        ST_SCAN
    } cjrq_state_t;

    // Padded query box, bounds kept at 18 bits so padding never wraps
    typedef struct packed {
        logic [BOUND_W-1:0] lo_x;
        logic [BOUND_W-1:0] lo_y;
        logic [BOUND_W-1:0] lo_z;
        logic [BOUND_W-1:0] hi_x;
        logic [BOUND_W-1:0] hi_y;
        logic [BOUND_W-1:0] hi_z;
    } cjrq_box_t;

    // Verdict of the entry compare unit
    typedef struct packed {
        logic older;
        logic in_box;
    } cjrq_match_t;

endpackage

`default_nettype wire

// ===== rtl/change_journal_region_query.sv =====
`default_nettype none
// Channel   Ports                                          Transfer
// command   start, busy, mode, corner_x/y/z, far_x/y/z,    start high while busy low
//           since_revision, pad_cells
// result    done, answer, current_revision                 done high, one cycle
//
// Record, clear and the unused selector end without a scan. A query ends on
// the revision checks, or else scans at most the ring count of entries, newest
// first: the scan reads one journal entry per cycle through the single read
// port of the entry memory and tests it in the shared compare unit.
// rst_n clears the ring pointers, counters and sequencer; entry memory is not
// cleared. Results cannot be held off by the receiver.

module change_journal_region_query #(
    parameter int JOURNAL_DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  mode,
    input  wire logic [15:0] corner_x,
    input  wire logic [15:0] corner_y,
    input  wire logic [15:0] corner_z,
    input  wire logic [15:0] far_x,
    input  wire logic [15:0] far_y,
    input  wire logic [15:0] far_z,
    input  wire logic [47:0] since_revision,
    input  wire logic [7:0]  pad_cells,
    output logic             done,
    output logic [2:0]       answer,
    output logic [47:0]      current_revision
);

    localparam int AW = (JOURNAL_DEPTH > 1) ? $clog2(JOURNAL_DEPTH) : 1;
    localparam int CW = $clog2(JOURNAL_DEPTH + 1);
    localparam int MW = cjrq_pkg::POS_W + cjrq_pkg::REV_W;
    localparam logic [AW-1:0] LAST_SLOT  = AW'(JOURNAL_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(JOURNAL_DEPTH);

    cjrq_pkg::cjrq_state_t  state_reg, state_next;
    logic [AW-1:0]          head_reg, head_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [47:0]            rev_reg, rev_next;
    logic [47:0]            floor_reg, floor_next;
    logic [AW-1:0]          scan_slot_reg, scan_slot_next;
    logic [CW-1:0]          left_reg, left_next;
    logic                   pend_reg, pend_next;
    logic                   done_reg, done_next;
    cjrq_pkg::cjrq_answer_t answer_reg, answer_next;
    logic [47:0]            rev_out_reg, rev_out_next;

    logic [15:0]            cx_reg, cy_reg, cz_reg;
    logic [15:0]            fx_reg, fy_reg, fz_reg;
    logic [47:0]            since_reg;
    logic [7:0]             pad_reg;
    cjrq_pkg::cjrq_box_t    box_reg, box_next;

    logic [MW-1:0]          journal_mem [JOURNAL_DEPTH];
    logic [AW-1:0]          rd_addr;
    logic [MW-1:0]          rd_data_reg;
    logic                   wr_en;

    logic                   accept;
    logic [47:0]            rev_bump;
    logic [7:0]             pad_eff;
    logic [AW-1:0]          slot_dec;
    logic [AW-1:0]          head_inc;
    logic                   full;
    logic                   no_changes;
    logic                   too_old;
    cjrq_pkg::cjrq_match_t  verdict;

    assign busy             = (state_reg != cjrq_pkg::ST_IDLE);
    assign accept           = start && !busy;
    assign done             = done_reg;
    assign answer           = answer_reg;
    assign current_revision = rev_out_reg;

    // Saturating revision step and ring pointer arithmetic
    assign rev_bump   = (rev_reg == cjrq_pkg::REV_MAX) ? rev_reg : rev_reg + 48'd1;
    assign slot_dec   = (scan_slot_reg == '0) ? LAST_SLOT : scan_slot_reg - AW'(1);
    assign head_inc   = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
    assign full       = (count_reg == FULL_COUNT);
    assign pad_eff    = pad_reg[7] ? 8'd0 : pad_reg;
    assign no_changes = (since_reg >= rev_reg);
    assign too_old    = (since_reg < floor_reg);

    // Shared entry compare unit
    cjrq_entry_match u_match (
        .entry_pos (rd_data_reg[cjrq_pkg::POS_W-1:0]),
        .entry_rev (rd_data_reg[MW-1:cjrq_pkg::POS_W]),
        .since     (since_reg),
        .box       (box_reg),
        .verdict   (verdict)
    );

    // Padded box bounds from the latched query
    always_comb
    begin
        box_next      = box_reg;
        box_next.lo_x = $signed({{2{cx_reg[15]}}, cx_reg}) - $signed({10'd0, pad_eff});
        box_next.lo_y = $signed({{2{cy_reg[15]}}, cy_reg}) - $signed({10'd0, pad_eff});
        box_next.lo_z = $signed({{2{cz_reg[15]}}, cz_reg}) - $signed({10'd0, pad_eff});
        box_next.hi_x = $signed({{2{fx_reg[15]}}, fx_reg}) + $signed({10'd0, pad_eff});
        box_next.hi_y = $signed({{2{fy_reg[15]}}, fy_reg}) + $signed({10'd0, pad_eff});
        box_next.hi_z = $signed({{2{fz_reg[15]}}, fz_reg}) + $signed({10'd0, pad_eff});
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cjrq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == cjrq_pkg::MODE_RECORD)
                    begin
                        state_next = cjrq_pkg::ST_RECORD;
                    end
                    else if (mode == cjrq_pkg::MODE_QUERY)
                    begin
                        state_next = cjrq_pkg::ST_CHECK;
                    end
                end
            end
            cjrq_pkg::ST_RECORD:
            begin
                state_next = cjrq_pkg::ST_IDLE;
            end
            cjrq_pkg::ST_CHECK:
            begin
                if (no_changes || too_old)
                begin
                    state_next = cjrq_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = cjrq_pkg::ST_SCAN;
                end
            end
            cjrq_pkg::ST_SCAN:
            begin
                if (!pend_reg || verdict.older || verdict.in_box)
                begin
                    state_next = cjrq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cjrq_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and result outputs
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        rev_next       = rev_reg;
        floor_next     = floor_reg;
        scan_slot_next = scan_slot_reg;
        left_next      = left_reg;
        pend_next      = pend_reg;
        done_next      = 1'b0;
        answer_next    = answer_reg;
        rev_out_next   = rev_out_reg;
        rd_addr        = head_reg;
        wr_en          = 1'b0;
        case (state_reg)
            cjrq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        cjrq_pkg::MODE_RECORD:
                        begin
                            // oldest slot is read now, in case the ring is full
                            rd_addr = head_reg;
                        end
                        cjrq_pkg::MODE_QUERY:
                        begin
                            scan_slot_next = (head_reg == '0) ? LAST_SLOT
                                                              : head_reg - AW'(1);
                            left_next      = count_reg;
                        end
                        cjrq_pkg::MODE_CLEAR:
                        begin
                            rev_next     = rev_bump;
                            floor_next   = rev_bump;
                            count_next   = '0;
                            done_next    = 1'b1;
                            answer_next  = cjrq_pkg::ANS_DONE;
                            rev_out_next = rev_bump;
                        end
                        default:
                        begin
                            done_next    = 1'b1;
                            answer_next  = cjrq_pkg::ANS_DONE;
                            rev_out_next = rev_reg;
                        end
                    endcase
                end
            end
            cjrq_pkg::ST_RECORD:
            begin
                // drop the oldest entry when full, then append at the head
                if (full)
                begin
                    if (rd_data_reg[MW-1:cjrq_pkg::POS_W] > floor_reg)
                    begin
                        floor_next = rd_data_reg[MW-1:cjrq_pkg::POS_W];
                    end
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
                wr_en        = 1'b1;
                head_next    = head_inc;
                rev_next     = rev_bump;
                done_next    = 1'b1;
                answer_next  = cjrq_pkg::ANS_DONE;
                rev_out_next = rev_bump;
            end
            cjrq_pkg::ST_CHECK:
            begin
                rev_out_next = rev_reg;
                if (no_changes)
                begin
                    done_next   = 1'b1;
                    answer_next = cjrq_pkg::ANS_NO_CHANGES;
                end
                else if (too_old)
                begin
                    done_next   = 1'b1;
                    answer_next = cjrq_pkg::ANS_HISTORY_UNAVAILABLE;
                end
                else
                begin
                    // issue the read of the newest entry
                    rd_addr        = scan_slot_reg;
                    scan_slot_next = slot_dec;
                    pend_next      = (left_reg != '0);
                    left_next      = (left_reg != '0) ? left_reg - CW'(1) : left_reg;
                end
            end
            cjrq_pkg::ST_SCAN:
            begin
                rev_out_next = rev_reg;
                // test the entry read last cycle while the next read goes out
                rd_addr        = scan_slot_reg;
                scan_slot_next = slot_dec;
                pend_next      = (left_reg != '0);
                left_next      = (left_reg != '0) ? left_reg - CW'(1) : left_reg;
                if (!pend_reg || verdict.older)
                begin
                    done_next   = 1'b1;
                    answer_next = cjrq_pkg::ANS_DISJOINT;
                end
                else if (verdict.in_box)
                begin
                    done_next   = 1'b1;
                    answer_next = cjrq_pkg::ANS_INTERSECTS;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cjrq_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= '0;
            floor_reg     <= '0;
            scan_slot_reg <= '0;
            left_reg      <= '0;
            pend_reg      <= 1'b0;
            done_reg      <= 1'b0;
            answer_reg    <= cjrq_pkg::ANS_DONE;
            rev_out_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            floor_reg     <= floor_next;
            scan_slot_reg <= scan_slot_next;
            left_reg      <= left_next;
            pend_reg      <= pend_next;
            done_reg      <= done_next;
            answer_reg    <= answer_next;
            rev_out_reg   <= rev_out_next;
        end
    end

    // Hold the command fields and the padded box
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg    <= corner_x;
            cy_reg    <= corner_y;
            cz_reg    <= corner_z;
            fx_reg    <= far_x;
            fy_reg    <= far_y;
            fz_reg    <= far_z;
            since_reg <= since_revision;
            pad_reg   <= pad_cells;
        end
        if (state_reg == cjrq_pkg::ST_CHECK)
        begin
            box_reg <= box_next;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            journal_mem[head_reg] <= {rev_bump, cz_reg, cy_reg, cx_reg};
        end
        rd_data_reg <= journal_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/cjrq_entry_match.sv =====
`default_nettype none

module cjrq_entry_match (
    input  wire logic [cjrq_pkg::POS_W-1:0] entry_pos,
    input  wire logic [cjrq_pkg::REV_W-1:0] entry_rev,
    input  wire logic [cjrq_pkg::REV_W-1:0] since,
    input  wire cjrq_pkg::cjrq_box_t        box,
    output cjrq_pkg::cjrq_match_t           verdict
);

    logic signed [cjrq_pkg::BOUND_W-1:0] cx;
    logic signed [cjrq_pkg::BOUND_W-1:0] cy;
    logic signed [cjrq_pkg::BOUND_W-1:0] cz;
    logic in_x;
    logic in_y;
    logic in_z;

    // Sign-extend the stored cell coordinates to bound width
    assign cx = $signed({{2{entry_pos[15]}}, entry_pos[15:0]});
    assign cy = $signed({{2{entry_pos[31]}}, entry_pos[31:16]});
    assign cz = $signed({{2{entry_pos[47]}}, entry_pos[47:32]});

    // Test each axis against the padded box
    assign in_x = (cx >= $signed(box.lo_x)) && (cx <= $signed(box.hi_x));
    assign in_y = (cy >= $signed(box.lo_y)) && (cy <= $signed(box.hi_y));
    assign in_z = (cz >= $signed(box.lo_z)) && (cz <= $signed(box.hi_z));

    // Stop the scan at an entry no newer than the since-revision
    assign verdict.older  = (entry_rev <= since);
    assign verdict.in_box = in_x && in_y && in_z;

endmodule

`default_nettype wire
